>>> src/adctc_pkg.sv
// Shared constants, types and helpers for the ADC temperature and supply calibration block.
package adctc_pkg;

  localparam int ADC_BITS  = 12;

  // Calibration scale factors and the widths that hold them.
  localparam int K_SCALE   = 6660;
  localparam int KSCALE_W  = 13;
  localparam int SUP_SCALE = 660;
  localparam int SUP_W     = 10;

  // Dividend widths of the three divisions.
  localparam int K_NUM_W   = ADC_BITS + KSCALE_W;
  localparam int P_W       = K_NUM_W + ADC_BITS;
  localparam int S_NUM_W   = ADC_BITS + SUP_W;

  // The divider retires two quotient bits per cycle.
  localparam int DIV_W     = ((P_W + 1) / 2) * 2;
  localparam int K_ITERS   = (K_NUM_W + 1) / 2;
  localparam int Q_ITERS   = (P_W + 1) / 2;
  localparam int S_ITERS   = (S_NUM_W + 1) / 2;
  localparam int CNT_W     = $clog2(Q_ITERS + 1);

  localparam int SUPPLY_W     = 15;
  localparam int TEMP_W       = 16;
  localparam int TEMP_OFFSET  = 3630;
  localparam int TEMP_SAT_LIM = TEMP_OFFSET + 32768;
  localparam int SUPPLY_MAX   = 32767;
  localparam logic signed [TEMP_W-1:0] TEMP_MIN = 16'sh8000;

  localparam int CAL_VREF_RST   = 1500;
  localparam int CAL_TSENSE_RST = 1700;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_VREF   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_TSENSE = 1'b1;

  typedef enum logic [1:0] {
    DIV_K,
    DIV_Q,
    DIV_S
  } div_op_t;

  typedef struct packed {
    logic    take_in;
    logic    div_start;
    div_op_t div_op;
    logic    mul_en;
    logic    hold_q;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } sts_t;

  // A zero divisor is treated as one.
  function automatic logic [ADC_BITS-1:0] nz(input logic [ADC_BITS-1:0] x);
    return (x == '0) ? ADC_BITS'(1) : x;
  endfunction

endpackage

>>> src/adctc_div.sv
// Iterative restoring divider that produces two quotient bits per cycle.
module adctc_div
  import adctc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [DIV_W-1:0]    dividend,
  input  logic [ADC_BITS-1:0] divisor,
  input  logic [CNT_W-1:0]    iters,
  output logic                done,
  output logic [DIV_W-1:0]    quotient
);

  logic [CNT_W-1:0]    count_r;
  logic                done_r;
  logic [DIV_W-1:0]    num_r;
  logic [DIV_W-1:0]    quot_r;
  logic [ADC_BITS-1:0] rem_r;
  logic [ADC_BITS-1:0] dsr_r;

  logic [ADC_BITS:0]   trial0;
  logic [ADC_BITS:0]   trial1;
  logic [ADC_BITS-1:0] rem_mid;
  logic [ADC_BITS-1:0] rem_nxt;
  logic                qb0;
  logic                qb1;

  always_comb begin
    trial0  = {rem_r, num_r[DIV_W-1]};
    qb0     = (trial0 >= {1'b0, dsr_r});
    rem_mid = qb0 ? ADC_BITS'(trial0 - {1'b0, dsr_r}) : trial0[ADC_BITS-1:0];
    trial1  = {rem_mid, num_r[DIV_W-2]};
    qb1     = (trial1 >= {1'b0, dsr_r});
    rem_nxt = qb1 ? ADC_BITS'(trial1 - {1'b0, dsr_r}) : trial1[ADC_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      done_r  <= 1'b0;
    end else if (start) begin
      count_r <= iters;
      done_r  <= 1'b0;
    end else if (count_r != '0) begin
      count_r <= count_r - CNT_W'(1);
      done_r  <= (count_r == CNT_W'(1));
    end else begin
      done_r  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r  <= dividend;
      dsr_r  <= divisor;
      rem_r  <= '0;
      quot_r <= '0;
    end else if (count_r != '0) begin
      num_r  <= {num_r[DIV_W-3:0], 2'b00};
      rem_r  <= rem_nxt;
      quot_r <= {quot_r[DIV_W-3:0], qb0, qb1};
    end
  end

  assign done     = done_r;
  assign quotient = quot_r;

endmodule

>>> src/adctc_datapath.sv
// Datapath: calibration registers, min/max tracking, multiplier, divider and result registers.
module adctc_datapath
  import adctc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  cmd_t                       cmd,
  output sts_t                       sts,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [ADC_BITS-1:0]        cfg_wdata,
  input  logic [ADC_BITS-1:0]        in_vref_raw,
  input  logic [ADC_BITS-1:0]        in_tsense_raw,
  output logic [SUPPLY_W-1:0]        out_supply_centivolts,
  output logic signed [TEMP_W-1:0]   out_temp_decidegrees,
  output logic [ADC_BITS-1:0]        out_min_vref,
  output logic [ADC_BITS-1:0]        out_max_vref,
  output logic [ADC_BITS-1:0]        out_min_tsense,
  output logic [ADC_BITS-1:0]        out_max_tsense
);

  logic [ADC_BITS-1:0] cal_vref_r;
  logic [ADC_BITS-1:0] cal_tsense_r;
  logic                seen_r;
  logic [ADC_BITS-1:0] min_v_r;
  logic [ADC_BITS-1:0] max_v_r;
  logic [ADC_BITS-1:0] min_t_r;
  logic [ADC_BITS-1:0] max_t_r;
  logic [ADC_BITS-1:0] v_r;
  logic [ADC_BITS-1:0] t_r;
  logic [P_W-1:0]      p_r;
  logic [P_W-1:0]      q_r;

  logic [SUPPLY_W-1:0]      supply_r;
  logic signed [TEMP_W-1:0] temp_r;
  logic [ADC_BITS-1:0]      omin_v_r;
  logic [ADC_BITS-1:0]      omax_v_r;
  logic [ADC_BITS-1:0]      omin_t_r;
  logic [ADC_BITS-1:0]      omax_t_r;

  logic [DIV_W-1:0]    div_num;
  logic [ADC_BITS-1:0] div_dsr;
  logic [CNT_W-1:0]    div_iters;
  logic [DIV_W-1:0]    quot;
  logic                div_done;

  logic [K_NUM_W-1:0]  k_num;
  logic [S_NUM_W-1:0]  s_num;
  logic [P_W:0]        q_sum;
  logic [S_NUM_W:0]    s_sum;
  logic [S_NUM_W-1:0]  s_val;
  logic [SUPPLY_W-1:0] supply_nxt;
  logic signed [TEMP_W-1:0] temp_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_vref_r   <= ADC_BITS'(CAL_VREF_RST);
      cal_tsense_r <= ADC_BITS'(CAL_TSENSE_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CAL_VREF:   cal_vref_r   <= cfg_wdata;
        REG_CAL_TSENSE: cal_tsense_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Extremes track every accepted sample; the first one seeds all four.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else if (cmd.take_in) begin
      seen_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      v_r <= in_vref_raw;
      t_r <= in_tsense_raw;
      if (!seen_r || in_vref_raw < min_v_r) begin
        min_v_r <= in_vref_raw;
      end
      if (!seen_r || in_vref_raw > max_v_r) begin
        max_v_r <= in_vref_raw;
      end
      if (!seen_r || in_tsense_raw < min_t_r) begin
        min_t_r <= in_tsense_raw;
      end
      if (!seen_r || in_tsense_raw > max_t_r) begin
        max_t_r <= in_tsense_raw;
      end
    end
  end

  always_comb begin
    k_num = K_NUM_W'(K_SCALE) * K_NUM_W'(cal_vref_r);
    s_num = S_NUM_W'(SUP_SCALE) * S_NUM_W'(cal_vref_r);
    case (cmd.div_op)
      DIV_K: begin
        div_num   = DIV_W'(k_num) << (DIV_W - 2 * K_ITERS);
        div_dsr   = nz(cal_tsense_r);
        div_iters = CNT_W'(K_ITERS);
      end
      DIV_Q: begin
        div_num   = DIV_W'(p_r) << (DIV_W - 2 * Q_ITERS);
        div_dsr   = nz(v_r);
        div_iters = CNT_W'(Q_ITERS);
      end
      DIV_S: begin
        div_num   = DIV_W'(s_num) << (DIV_W - 2 * S_ITERS);
        div_dsr   = nz(v_r);
        div_iters = CNT_W'(S_ITERS);
      end
      default: begin
        div_num   = '0;
        div_dsr   = ADC_BITS'(1);
        div_iters = '0;
      end
    endcase
  end

  adctc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_num),
    .divisor  (div_dsr),
    .iters    (div_iters),
    .done     (div_done),
    .quotient (quot)
  );

  assign sts.div_done = div_done;

  assign q_sum = {1'b0, quot[P_W-1:0]} + (P_W + 1)'(1);

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      p_r <= P_W'(quot[K_NUM_W-1:0]) * P_W'(t_r);
    end
    if (cmd.hold_q) begin
      q_r <= q_sum[P_W:1];
    end
  end

  // Final rounding and saturation; the supply quotient is still in the divider.
  always_comb begin
    s_sum      = {1'b0, quot[S_NUM_W-1:0]} + (S_NUM_W + 1)'(1);
    s_val      = s_sum[S_NUM_W:1];
    supply_nxt = (s_val > S_NUM_W'(SUPPLY_MAX)) ? SUPPLY_W'(SUPPLY_MAX)
                                                : s_val[SUPPLY_W-1:0];
    temp_nxt   = (q_r > P_W'(TEMP_SAT_LIM)) ? TEMP_MIN
                 : TEMP_W'(TEMP_W'(TEMP_OFFSET) - q_r[TEMP_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      supply_r <= supply_nxt;
      temp_r   <= temp_nxt;
      omin_v_r <= min_v_r;
      omax_v_r <= max_v_r;
      omin_t_r <= min_t_r;
      omax_t_r <= max_t_r;
    end
  end

  assign out_supply_centivolts = supply_r;
  assign out_temp_decidegrees  = temp_r;
  assign out_min_vref          = omin_v_r;
  assign out_max_vref          = omax_v_r;
  assign out_min_tsense        = omin_t_r;
  assign out_max_tsense        = omax_t_r;

endmodule

>>> src/adctc_ctrl.sv
// Controller state machine that sequences the three divisions and the result transfer.
module adctc_ctrl
  import adctc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output cmd_t cmd,
  input  sts_t sts
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KSTART,
    ST_KWAIT,
    ST_MUL,
    ST_QSTART,
    ST_QWAIT,
    ST_SSTART,
    ST_SWAIT,
    ST_FIN
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  always_comb begin
    cmd           = '0;
    cmd.div_op    = DIV_K;
    state_nxt     = state_r;
    case (state_r)
      ST_IDLE: begin
        cmd.take_in = in_valid;
        if (in_valid) begin
          state_nxt = ST_KSTART;
        end
      end
      ST_KSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = DIV_K;
        state_nxt     = ST_KWAIT;
      end
      ST_KWAIT: begin
        if (sts.div_done) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = ST_QSTART;
      end
      ST_QSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = DIV_Q;
        state_nxt     = ST_QWAIT;
      end
      ST_QWAIT: begin
        if (sts.div_done) begin
          state_nxt = ST_SSTART;
        end
      end
      ST_SSTART: begin
        // The temperature quotient is captured as the supply division loads.
        cmd.hold_q    = 1'b1;
        cmd.div_start = 1'b1;
        cmd.div_op    = DIV_S;
        state_nxt     = ST_SWAIT;
      end
      ST_SWAIT: begin
        if (sts.div_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    out_valid_nxt = cmd.load_out | (out_valid_r & out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> src/adc_temp_vdd_calibrate_track_core.sv
// Top level of the ADC temperature and supply calibration block with min/max tracking.
//
// Input channel: in_valid/in_stall transfer one pair of raw 12-bit readings, the internal
// reference (in_vref_raw) and the temperature sensor (in_tsense_raw).
// Result channel: out_valid/out_stall transfer the supply in hundredths of a volt, the
// temperature in tenths of a degree and the running extremes of both raw channels.
// Configuration: cfg_valid/cfg_ready write cal_vref (index 0) or cal_tsense (index 1);
// cfg_ready is always high, and writes are expected only while the block is idle.
// One shared divider retiring two quotient bits per cycle performs all three divisions
// in turn; the next item is taken only once the previous result is in the output register.
// A finished result sits in the output register while the next item is already being
// worked on; if the receiver still stalls when the next result is ready, the block holds
// that result internally and keeps in_stall high until the output register frees up.
// Synchronous reset restores the calibration words to 1500 and 1700, forgets the tracked
// extremes (the next sample seeds them) and drops out_valid.
module adc_temp_vdd_calibrate_track_core
  import adctc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [ADC_BITS-1:0]      in_vref_raw,
  input  logic [ADC_BITS-1:0]      in_tsense_raw,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [SUPPLY_W-1:0]      out_supply_centivolts,
  output logic signed [TEMP_W-1:0] out_temp_decidegrees,
  output logic [ADC_BITS-1:0]      out_min_vref,
  output logic [ADC_BITS-1:0]      out_max_vref,
  output logic [ADC_BITS-1:0]      out_min_tsense,
  output logic [ADC_BITS-1:0]      out_max_tsense,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [ADC_BITS-1:0]      cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  adctc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  adctc_datapath u_datapath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .cfg_we                (cfg_valid & cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_vref_raw           (in_vref_raw),
    .in_tsense_raw         (in_tsense_raw),
    .out_supply_centivolts (out_supply_centivolts),
    .out_temp_decidegrees  (out_temp_decidegrees),
    .out_min_vref          (out_min_vref),
    .out_max_vref          (out_max_vref),
    .out_min_tsense        (out_min_tsense),
    .out_max_tsense        (out_max_tsense)
  );

endmodule

>>> tb/adc_temp_vdd_calibrate_track_core_test.sv
// Self-checking testbench for the ADC temperature and supply calibration core.
module adc_temp_vdd_calibrate_track_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import adctc_pkg::*;

  localparam int ADC_MAX       = (1 << ADC_BITS) - 1;
  localparam int STALL_LIMIT   = 4000;
  localparam int HOLD_OFF      = 400;
  localparam int PHASE_ITEMS   = 50;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 60;

  typedef struct packed {
    logic [SUPPLY_W-1:0]      supply;
    logic signed [TEMP_W-1:0] temp;
    logic [ADC_BITS-1:0]      min_vref;
    logic [ADC_BITS-1:0]      max_vref;
    logic [ADC_BITS-1:0]      min_tsense;
    logic [ADC_BITS-1:0]      max_tsense;
  } reading_t;

  // Tracks calibration and running extremes, predicts each reading and checks it.
  class calib_scoreboard;
    logic [ADC_BITS-1:0] cal_vref;
    logic [ADC_BITS-1:0] cal_tsense;
    int                  lo_ref, hi_ref, lo_temp, hi_temp;
    reading_t            readings_due[$];
    int                  errors;

    function new();
      cal_vref   = ADC_BITS'(CAL_VREF_RST);
      cal_tsense = ADC_BITS'(CAL_TSENSE_RST);
      lo_ref     = 32767;
      hi_ref     = -32768;
      lo_temp    = 32767;
      hi_temp    = -32768;
      errors     = 0;
    endfunction

    function void write_cal(logic [CFG_IDX_W-1:0] idx, logic [ADC_BITS-1:0] val);
      if (idx == REG_CAL_VREF) cal_vref = val;
      else if (idx == REG_CAL_TSENSE) cal_tsense = val;
    endfunction

    function int pending();
      return readings_due.size();
    endfunction

    function void note_sample(logic [ADC_BITS-1:0] v, logic [ADC_BITS-1:0] t);
      longint unsigned vd, td, k, q, s;
      longint          temp;
      reading_t        r;
      if (int'(v) < lo_ref) lo_ref = int'(v);
      if (int'(v) > hi_ref) hi_ref = int'(v);
      if (int'(t) < lo_temp) lo_temp = int'(t);
      if (int'(t) > hi_temp) hi_temp = int'(t);
      // Zero divisors are taken as one.
      vd = (v == '0) ? 64'd1 : longint'(v);
      td = (cal_tsense == '0) ? 64'd1 : longint'(cal_tsense);
      k  = (longint'(K_SCALE) * longint'(cal_vref)) / td;
      q  = (64'd1 + (k * longint'(t)) / vd) / 64'd2;
      if (q > longint'(TEMP_SAT_LIM)) temp = -32768;
      else temp = longint'(TEMP_OFFSET) - longint'(q);
      if (temp < -32768) temp = -32768;
      if (temp > 32767) temp = 32767;
      s = ((longint'(SUP_SCALE) * longint'(cal_vref)) / vd + 64'd1) / 64'd2;
      if (s > longint'(SUPPLY_MAX)) s = longint'(SUPPLY_MAX);
      r.supply     = SUPPLY_W'(s);
      r.temp       = TEMP_W'(temp);
      r.min_vref   = ADC_BITS'(lo_ref);
      r.max_vref   = ADC_BITS'(hi_ref);
      r.min_tsense = ADC_BITS'(lo_temp);
      r.max_tsense = ADC_BITS'(hi_temp);
      readings_due.push_back(r);
    endfunction

    function void field_cmp(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        errors++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_reading(reading_t got);
      reading_t want;
      if (readings_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected reading: expected none, actual %h", $time, got);
        return;
      end
      want = readings_due.pop_front();
      field_cmp("supply_centivolts", want.supply, got.supply);
      field_cmp("temp_decidegrees", want.temp, got.temp);
      field_cmp("min_vref", want.min_vref, got.min_vref);
      field_cmp("max_vref", want.max_vref, got.max_vref);
      field_cmp("min_tsense", want.min_tsense, got.min_tsense);
      field_cmp("max_tsense", want.max_tsense, got.max_tsense);
    endfunction
  endclass

  logic                     clk           = 1'b0;
  logic                     rst_n         = 1'b0;
  logic                     in_valid      = 1'b0;
  logic                     in_stall;
  logic [ADC_BITS-1:0]      in_vref_raw   = '0;
  logic [ADC_BITS-1:0]      in_tsense_raw = '0;
  logic                     out_valid;
  logic                     out_stall     = 1'b0;
  logic [SUPPLY_W-1:0]      out_supply_centivolts;
  logic signed [TEMP_W-1:0] out_temp_decidegrees;
  logic [ADC_BITS-1:0]      out_min_vref;
  logic [ADC_BITS-1:0]      out_max_vref;
  logic [ADC_BITS-1:0]      out_min_tsense;
  logic [ADC_BITS-1:0]      out_max_tsense;
  logic                     cfg_valid     = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index     = REG_CAL_VREF;
  logic [ADC_BITS-1:0]      cfg_wdata     = '0;

  calib_scoreboard sb = new();

  int in_idle_pct  = 0;
  int rx_stall_pct = 0;
  int hold_cycles  = 0;
  int quiet_cycles = 0;

  always #6 clk = ~clk;

  adc_temp_vdd_calibrate_track_core DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_vref_raw           (in_vref_raw),
    .in_tsense_raw         (in_tsense_raw),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_supply_centivolts (out_supply_centivolts),
    .out_temp_decidegrees  (out_temp_decidegrees),
    .out_min_vref          (out_min_vref),
    .out_max_vref          (out_max_vref),
    .out_min_tsense        (out_min_tsense),
    .out_max_tsense        (out_max_tsense),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata)
  );

  // Mostly uniform readings, with extra weight on zero, full scale and tiny values.
  function automatic logic [ADC_BITS-1:0] pick_reading();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return ADC_BITS'(ADC_MAX);
      2: return ADC_BITS'($urandom_range(0, 15));
      default: return ADC_BITS'($urandom_range(0, ADC_MAX));
    endcase
  endfunction

  // Leaves in_valid high after the transfer; the caller decides whether to idle.
  task automatic send_sample(logic [ADC_BITS-1:0] v, logic [ADC_BITS-1:0] t);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_vref_raw   <= v;
    in_tsense_raw <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(v, t);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADC_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_cal(idx, val);
  endtask

  task automatic set_calibration(logic [ADC_BITS-1:0] vref, logic [ADC_BITS-1:0] tsense);
    write_reg(REG_CAL_VREF, vref);
    write_reg(REG_CAL_TSENSE, tsense);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_idling(int mode);
    case (mode % 4)
      0: begin in_idle_pct = 0;  rx_stall_pct = 0;  end
      1: begin in_idle_pct = 83; rx_stall_pct = 0;  end
      2: begin in_idle_pct = 0;  rx_stall_pct = 83; end
      default: begin in_idle_pct = 32; rx_stall_pct = 32; end
    endcase
  endtask

  // Result side: check each transfer, then choose the stall for the next cycle.
  initial begin : result_side
    reading_t got;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.supply     = out_supply_centivolts;
        got.temp       = out_temp_decidegrees;
        got.min_vref   = out_min_vref;
        got.max_vref   = out_max_vref;
        got.min_tsense = out_min_tsense;
        got.max_tsense = out_max_tsense;
        sb.check_reading(got);
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("** adc_temp_vdd_calibrate_track_core: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    logic [ADC_BITS-1:0] cal_v [8];
    logic [ADC_BITS-1:0] cal_t [8];
    logic [ADC_BITS-1:0] dir_v [12];
    logic [ADC_BITS-1:0] dir_t [12];
    cal_v = '{12'd4095, 12'd0, 12'd4095, 12'd1, 12'd0, 12'd1500, 12'd0, 12'd0};
    cal_t = '{12'd1, 12'd4095, 12'd0, 12'd4095, 12'd0, 12'd1700, 12'd0, 12'd0};
    cal_v[6] = ADC_BITS'($urandom_range(0, ADC_MAX));
    cal_t[6] = ADC_BITS'($urandom_range(0, ADC_MAX));
    cal_v[7] = ADC_BITS'($urandom_range(0, ADC_MAX));
    cal_t[7] = ADC_BITS'($urandom_range(1, ADC_MAX));
    // Zero reference reading, full scale, a huge quotient (1, 4095) and alternating bits.
    dir_v = '{12'd2048, 12'd0, 12'd4095, 12'd1, 12'd0, 12'd4095, 12'd1, 12'h555,
              12'hAAA, 12'd1500, 12'd2, 12'd4094};
    dir_t = '{12'd2048, 12'd0, 12'd4095, 12'd4095, 12'd4095, 12'd0, 12'd0, 12'hAAA,
              12'h555, 12'd1700, 12'd4095, 12'd1};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset calibration first, then every register setting in turn.
    set_idling(0);
    foreach (dir_v[i]) send_sample(dir_v[i], dir_t[i]);
    wait_drained();
    for (int p = 0; p < 8; p++) begin
      set_calibration(cal_v[p], cal_t[p]);
      set_idling(p);
      // Hold the result side off long enough for the core to back up its input.
      if (p == 4) hold_cycles = HOLD_OFF;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_sample(pick_reading(), pick_reading());
        if (n == PHASE_ITEMS / 2) wait_drained();
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** adc_temp_vdd_calibrate_track_core: PASSED **");
    end else begin
      $display("** adc_temp_vdd_calibrate_track_core: FAILED **");
    end
    $finish;
  end

endmodule
